// File: rtl/psh_pkg.sv
// Shared types, constants and power tables for the Phong specular highlight block.
package psh_pkg;

  localparam int POW_TABLE_BITS = 8;
  localparam int TBL_SIZE       = 1 << POW_TABLE_BITS;
  localparam int MAG_W          = 41;
  localparam int P_W            = 6;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;

  localparam logic REG_COEFF    = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  localparam logic [15:0] COEFF_RESET    = 16'd4096;
  localparam logic [15:0] EXPONENT_RESET = 16'd10240;

  typedef enum logic [1:0] {
    KIND_BLACK,
    KIND_UNITY,
    KIND_POWER
  } spec_kind_t;

  typedef struct packed {
    logic        [15:0] light_red;
    logic        [15:0] light_green;
    logic        [15:0] light_blue;
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] viewer_x;
    logic signed [15:0] viewer_y;
    logic signed [15:0] viewer_z;
  } psh_in_t;

  typedef struct packed {
    logic [15:0] spec_red;
    logic [15:0] spec_green;
    logic [15:0] spec_blue;
  } psh_out_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } light_t;

  typedef struct packed {
    spec_kind_t         kind;
    logic [MAG_W-1:0]   mag;
    light_t             light;
  } queue_item_t;

  typedef logic [TBL_SIZE-1:0][15:0] log_tbl_t;
  typedef logic [TBL_SIZE-1:0][31:0] exp_tbl_t;

  // log2(1 + i/2^B) in Q.16, one result bit per squaring
  function automatic log_tbl_t build_log_tbl();
    log_tbl_t    tbl;
    logic [63:0] y;
    logic [15:0] r;
    for (int i = 0; i < TBL_SIZE; i++) begin
      y = 64'h4000_0000 + (64'(i) << (30 - POW_TABLE_BITS));
      r = '0;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        r = {r[14:0], 1'b0};
        if (y >= 64'h8000_0000) begin
          y    = y >> 1;
          r[0] = 1'b1;
        end
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] res;
    logic [63:0] bval;
    xr   = x;
    res  = '0;
    bval = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (xr >= res + bval) begin
        xr  = xr - (res + bval);
        res = (res >> 1) + bval;
      end else begin
        res = res >> 1;
      end
      bval = bval >> 2;
    end
    return res;
  endfunction

  // 2^(j/2^B) in Q1.30 as a product of successive square roots of two
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0] root [POW_TABLE_BITS];
    logic [63:0] rt;
    logic [63:0] e;
    rt = 64'h8000_0000;
    for (int k = 0; k < POW_TABLE_BITS; k++) begin
      rt      = isqrt64(rt << 30);
      root[k] = rt;
    end
    for (int j = 0; j < TBL_SIZE; j++) begin
      e = 64'h4000_0000;
      for (int k = 1; k <= POW_TABLE_BITS; k++) begin
        if (((j >> (POW_TABLE_BITS - k)) & 1) != 0) begin
          e = (e * root[k-1]) >> 30;
        end
      end
      tbl[j] = e[31:0];
    end
    return tbl;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();
  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

// File: rtl/phong_specular_highlight.sv
// Phong specular highlight: reflection, power via log2/exp2 tables, per-channel scaling.
//
// Input channel in_valid/in_stall/in_data carries one shading sample per transaction:
// light color plus ray, normal and viewer vectors. Output channel
// out_valid/out_stall/out_data carries one specular color per sample, in order.
// A transaction completes at a rising edge with valid high and stall low.
// Throughput is one sample per cycle when nothing stalls. From input to output a
// sample passes six front stages, the four-entry queue, six back stages and the
// output register.
// The front end stalls only when the queue is full; the back end stalls only when
// a finished result sits unaccepted in the output register, so a stalled receiver
// freezes the back pipe, then fills the queue, then holds in_stall high.
// cfg_we writes highlight_coeff (index 0) or shininess_exponent (index 1);
// writes are expected only while no sample is in flight.
// rst (synchronous) empties the pipes and queue and restores the register
// defaults: coefficient 1.0 and exponent 40.0.
module phong_specular_highlight import psh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  psh_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output psh_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] highlight_coeff;
  logic [15:0] shininess_exponent;

  logic        push, pop, full, empty;
  queue_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      highlight_coeff    <= COEFF_RESET;
      shininess_exponent <= EXPONENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFF:    highlight_coeff    <= cfg_data;
        REG_EXPONENT: shininess_exponent <= cfg_data;
      endcase
    end
  end

  psh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .exponent   (shininess_exponent),
    .push       (push),
    .push_item  (push_item),
    .queue_full (full)
  );

  psh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  psh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coeff     (highlight_coeff),
    .exponent  (shininess_exponent),
    .empty     (empty),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/psh_front.sv
// Front end: reflection vector, dot with viewer, and classification of the sample.
module psh_front import psh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  psh_in_t     in_data,
  input  logic [15:0] exponent,
  output logic        push,
  output queue_item_t push_item,
  input  logic        queue_full
);

  logic en;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [15:0] ray_in [3];
  logic signed [15:0] nrm_in [3];
  logic signed [15:0] view_in [3];
  light_t             light_in;

  logic signed [31:0] rn1 [3];
  logic signed [15:0] nrm1 [3], ray1 [3], view1 [3];
  logic signed [33:0] d2;
  logic signed [15:0] nrm2 [3], ray2 [3], view2 [3];
  logic signed [50:0] dn3 [3];
  logic signed [15:0] ray3 [3], view3 [3];
  logic signed [24:0] refl4 [3];
  logic signed [15:0] view4 [3];
  logic signed [40:0] rv5 [3];
  light_t             light1, light2, light3, light4, light5, light6;
  spec_kind_t         kind6;
  logic [MAG_W-1:0]   mag6;

  logic signed [52:0] num [3];
  logic signed [24:0] quo [3];
  logic signed [42:0] s_sum;
  spec_kind_t         kind_next;

  assign ray_in[0]  = in_data.ray_x;
  assign ray_in[1]  = in_data.ray_y;
  assign ray_in[2]  = in_data.ray_z;
  assign nrm_in[0]  = in_data.normal_x;
  assign nrm_in[1]  = in_data.normal_y;
  assign nrm_in[2]  = in_data.normal_z;
  assign view_in[0] = in_data.viewer_x;
  assign view_in[1] = in_data.viewer_y;
  assign view_in[2] = in_data.viewer_z;
  assign light_in   = '{red: in_data.light_red, green: in_data.light_green,
                        blue: in_data.light_blue};

  assign en        = !(v6 && queue_full);
  assign in_stall  = !en;
  assign push      = v6 && !queue_full;
  assign push_item = '{kind: kind6, mag: mag6, light: light6};

  // reflected component truncates toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (53'(dn3[i]) <<< 1) - (53'(ray3[i]) <<< 28);
      quo[i] = 25'(num[i] >>> 28);
      if (num[i][52] && (num[i][27:0] != '0)) begin
        quo[i] = quo[i] + 25'sd1;
      end
    end
  end

  always_comb begin
    s_sum = 43'(rv5[0]) + 43'(rv5[1]) + 43'(rv5[2]);
    if (s_sum[42]) begin
      kind_next = KIND_BLACK;
    end else if (s_sum == '0) begin
      kind_next = (exponent == '0) ? KIND_UNITY : KIND_BLACK;
    end else begin
      kind_next = KIND_POWER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rn1[i]   <= 32'(ray_in[i]) * 32'(nrm_in[i]);
        nrm1[i]  <= nrm_in[i];
        ray1[i]  <= ray_in[i];
        view1[i] <= view_in[i];
        nrm2[i]  <= nrm1[i];
        ray2[i]  <= ray1[i];
        view2[i] <= view1[i];
        dn3[i]   <= 51'(d2) * 51'(nrm2[i]);
        ray3[i]  <= ray2[i];
        view3[i] <= view2[i];
        refl4[i] <= quo[i];
        view4[i] <= view3[i];
        rv5[i]   <= 41'(refl4[i]) * 41'(view4[i]);
      end
      d2     <= 34'(rn1[0]) + 34'(rn1[1]) + 34'(rn1[2]);
      light1 <= light_in;
      light2 <= light1;
      light3 <= light2;
      light4 <= light3;
      light5 <= light4;
      light6 <= light5;
      kind6  <= kind_next;
      mag6   <= s_sum[MAG_W-1:0];
    end
  end

endmodule

// File: rtl/psh_queue.sv
// Small FIFO between the classifying front end and the power/scale back end.
module psh_queue import psh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output queue_item_t pop_item,
  output logic        empty
);

  queue_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// File: rtl/psh_back.sv
// Back end: log2, exponent multiply, exp2, coefficient and light scaling with saturation.
module psh_back import psh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] coeff,
  input  logic [15:0] exponent,
  input  logic        empty,
  input  queue_item_t pop_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output psh_out_t    out_data
);

  logic en;
  logic b1, b2, b3, b4, b5, b6;

  spec_kind_t kind1, kind2, kind3;
  logic [MAG_W-1:0] mag1;
  logic [P_W-1:0]   p1;
  logic signed [23:0] g2;
  logic signed [40:0] pw3;
  logic [31:0] mant4;
  logic signed [16:0] n4, n5, n6;
  logic [47:0] mc5;
  logic [63:0] prod6 [3];
  light_t light1, light2, light3, light4, light5;

  logic [P_W-1:0] lead;
  logic [MAG_W+POW_TABLE_BITS-1:0] shifted;
  logic [POW_TABLE_BITS-1:0] idx;
  logic signed [23:0] g_next;
  logic [31:0] mant_next;
  logic signed [16:0] n_next;
  logic signed [17:0] t6;

  function automatic logic [15:0] scale_sat(input logic [63:0] prod,
                                            input logic signed [17:0] t);
    logic [63:0] v;
    v = prod >> t[5:0];
    if (prod == '0) return 16'd0;
    if (t <= 18'sd0) return 16'hFFFF;
    if (t >= 18'sd64) return 16'd0;
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  assign en  = !(out_valid && out_stall);
  assign pop = en && !empty;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (pop_item.mag[i]) lead = P_W'(i);
    end
  end

  always_comb begin
    shifted = {mag1, {POW_TABLE_BITS{1'b0}}} >> p1;
    idx     = shifted[POW_TABLE_BITS-1:0];
    g_next  = 24'((24'(p1) - 24'd28) << 16) + 24'(LOG_TBL[idx]);
  end

  always_comb begin
    case (kind3)
      KIND_POWER: begin
        mant_next = EXP_TBL[pw3[23 -: POW_TABLE_BITS]];
        n_next    = pw3[40:24];
      end
      KIND_UNITY: begin
        mant_next = 32'h4000_0000;
        n_next    = '0;
      end
      default: begin
        mant_next = '0;
        n_next    = '0;
      end
    endcase
  end

  assign t6 = 18'sd42 - 18'(n6);

  always_ff @(posedge clk) begin
    if (rst) begin
      {b1, b2, b3, b4, b5, b6, out_valid} <= '0;
    end else if (en) begin
      b1        <= pop;
      b2        <= b1;
      b3        <= b2;
      b4        <= b3;
      b5        <= b4;
      b6        <= b5;
      out_valid <= b6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1     <= lead;
      mag1   <= pop_item.mag;
      kind1  <= pop_item.kind;
      light1 <= pop_item.light;
      g2     <= g_next;
      kind2  <= kind1;
      light2 <= light1;
      pw3    <= 41'(g2) * 41'(signed'({1'b0, exponent}));
      kind3  <= kind2;
      light3 <= light2;
      mant4  <= mant_next;
      n4     <= n_next;
      light4 <= light3;
      mc5    <= 48'(mant4) * 48'(coeff);
      n5     <= n4;
      light5 <= light4;
      prod6[0] <= 64'(mc5) * 64'(light5.red);
      prod6[1] <= 64'(mc5) * 64'(light5.green);
      prod6[2] <= 64'(mc5) * 64'(light5.blue);
      n6     <= n5;
      out_data.spec_red   <= scale_sat(prod6[0], t6);
      out_data.spec_green <= scale_sat(prod6[1], t6);
      out_data.spec_blue  <= scale_sat(prod6[2], t6);
    end
  end

endmodule

// File: rtl/psh_checker.sv
// Port-level checks for the specular highlight block, bound to the top level.
module psh_checker import psh_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input psh_out_t out_data
);

  a_reset_flush: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one drained cycle at the output frees a queue slot for the front end
  a_flow: assert property (@(posedge clk) !rst && !out_stall |=> !in_stall)
    else $error("input stalled although output drains");

endmodule

bind phong_specular_highlight psh_checker u_psh_checker (.*);
